// File: sv/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
    localparam logic signed [VAL_W-1:0] GET_MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } result_t;

endpackage

// File: sv/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
// Requests arrive on the s_ stream: s_tuser carries the operation (get or put),
// s_tdata the key and the value. Every request yields exactly one result
// transaction on the m_ stream: m_tuser carries the hit and evicted flags,
// m_tdata the read value and the evicted key.
// A request accepted on the s_ stream is held in an input register, resolved
// against the entry table and written to the output register, which drives
// m_tvalid. One request per cycle is sustained while the receiver does not
// stall; the per-request work is a parallel key match plus a rank update
// over all entries, done between those two registers.
// When the receiver stalls, the result stays in the output register and one
// more request may wait in the input register; then s_tready drops.
// Reset empties the cache (all entries invalid, occupancy zero) and sets the
// capacity register to 16. The capacity is written through cfg_wr_en and
// cfg_wr_data while no request is in flight, which the user must ensure; the
// block does not enforce it. 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]  m_tuser,   // [0] hit, [1] evicted
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    logic                              in_valid_reg;
    lrukv_pkg::req_t                   req_reg;
    logic                              out_valid_reg;
    lrukv_pkg::result_t                res_reg;
    logic [lrukv_pkg::CFG_W-1:0]       cap_reg;
    lrukv_pkg::result_t                result;
    logic                              advance;
    logic                              s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    lrukv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_reg),
        .req_fire (advance),
        .cap      (cap_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lrukv_pkg::CAP_RESET;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_reg.mode  <= s_tuser[0];
            req_reg.key   <= s_tdata[31:0];
            req_reg.value <= s_tdata[63:32];
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.evicted_key, res_reg.read_value};
    assign m_tuser  = {res_reg.evicted, res_reg.hit};

    // A resolved request always lands in the output register.
    a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("resolved request did not reach the output register");

    // Eviction only happens for a put of a key that was not present.
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.evicted) |-> !res_reg.hit)
        else $error("eviction reported together with a hit");

    // A waiting request is neither lost nor altered while the output is blocked.
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(req_reg)))
        else $error("pending request changed while stalled");

endmodule

// File: sv/lrukv_store.sv
// Entry storage, parallel key match and recency-rank update of the LRU cache.
module lrukv_store #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrukv_pkg::req_t               req,
    input  logic                          req_fire,
    input  logic [lrukv_pkg::CFG_W-1:0]   cap,
    output lrukv_pkg::result_t            result
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > lrukv_pkg::CFG_W) ? OW : lrukv_pkg::CFG_W;

    logic signed [lrukv_pkg::KEY_W-1:0] key_reg   [ENTRIES];
    logic signed [lrukv_pkg::VAL_W-1:0] value_reg [ENTRIES];
    logic [RW-1:0]                      rank_reg  [ENTRIES];
    logic [RW-1:0]                      rank_next [ENTRIES];
    logic [ENTRIES-1:0]                 valid_reg;
    logic [ENTRIES-1:0]                 valid_next;
    logic [OW-1:0]                      occ_reg;
    logic [OW-1:0]                      occ_next;

    logic [ENTRIES-1:0]                 match;
    logic [ENTRIES-1:0]                 lru;
    logic [ENTRIES-1:0]                 avail;
    logic [ENTRIES-1:0]                 ins;
    logic [ENTRIES-1:0]                 key_we;
    logic [ENTRIES-1:0]                 val_we;
    logic                               hit;
    logic                               is_put;
    logic                               full;
    logic                               do_evict;
    logic [RW-1:0]                      hit_rank;
    logic [OW-1:0]                      occ_m1;
    logic [CW-1:0]                      occ_ext;
    logic [CW-1:0]                      cap_floor;
    logic signed [lrukv_pkg::VAL_W-1:0] hit_value;
    logic signed [lrukv_pkg::KEY_W-1:0] lru_key;

    always_comb
    begin
        is_put    = (req.mode == lrukv_pkg::MODE_PUT);
        occ_m1    = occ_reg - OW'(1);
        occ_ext   = CW'(occ_reg);
        cap_floor = (cap == '0) ? CW'(1) : CW'(cap);
        full      = (occ_ext >= CW'(ENTRIES)) || (occ_ext >= cap_floor);

        hit_rank  = '0;
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            // Ranks of valid entries are always a permutation of 0..occupancy-1,
            // so the least recent entry is the one ranked occupancy-1.
            lru[i]   = valid_reg[i] && (rank_reg[i] == occ_m1[RW-1:0]);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (lru[i])
            begin
                lru_key = lru_key | key_reg[i];
            end
        end
        hit      = |match;
        do_evict = is_put && !hit && full;

        // A new key takes the lowest free slot once the victim is released.
        avail = ~valid_reg | (do_evict ? lru : '0);
        ins   = avail & (~avail + ENTRIES'(1));

        valid_next = valid_reg;
        occ_next   = occ_reg;
        key_we     = '0;
        val_we     = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (hit)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            if (is_put)
            begin
                val_we = match;
            end
        end
        else if (is_put)
        begin
            valid_next = (valid_reg & ~(do_evict ? lru : '0)) | ins;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (ins[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_next[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            key_we = ins;
            val_we = ins;
            if (!do_evict)
            begin
                occ_next = occ_reg + OW'(1);
            end
        end

        result.hit         = hit;
        result.read_value  = is_put ? '0 : (hit ? hit_value : lrukv_pkg::GET_MISS_VALUE);
        result.evicted     = do_evict;
        result.evicted_key = do_evict ? lru_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else if (req_fire)
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (req_fire)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (req_fire && key_we[i])
            begin
                key_reg[i] <= req.key;
            end
            if (req_fire && val_we[i])
            begin
                value_reg[i] <= req.value;
            end
        end
    end

endmodule
